// ===== design/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg: shared types and constants for the fractal value noise block
// Configuration register indexes, the multiply-xor hash constants and the
// per-beat control type.
// ----------------------------------------------------------------------------
`default_nettype none
package fvn_pkg;
    localparam int unsigned MAX_RES_DEF  = 4096;
    localparam int unsigned OCTAVES_DEF  = 5;
    localparam int unsigned FRAC_DEF     = 24;

    localparam int unsigned IDX_W    = 12;
    localparam int unsigned RES_W    = 13;
    localparam int unsigned HEIGHT_W = 24;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED       = 2'd0,
        REG_TILE_X     = 2'd1,
        REG_TILE_Y     = 2'd2,
        REG_RESOLUTION = 2'd3
    } t_cfg_reg;

    localparam logic [63:0] HASH_KX = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_KY = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] HASH_KK = 64'h165667B19E3779F9;
    localparam logic [63:0] HASH_KM = 64'hBF58476D1CE4E5B9;

    // Control carried with each beat at the tail of the valid chain.
    typedef struct packed {
        logic valid;
    } t_beat_ctl;
endpackage
`default_nettype wire

// ===== design/fvn_mul64.sv =====
// ----------------------------------------------------------------------------
// fvn_mul64: pipelined 64 x 64 -> low 64 bits multiplier
// Three 32x32 partial products registered, then summed in a second stage.
// Advances when i_en.
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_mul64 (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] n_ll;
    logic [63:0] n_lh;
    logic [63:0] n_hl;

    assign n_ll = 64'(i_a[31:0]) * 64'(i_b[31:0]);
    assign n_lh = 64'(i_a[31:0]) * 64'(i_b[63:32]);
    assign n_hl = 64'(i_a[63:32]) * 64'(i_b[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh[31:0];
            r_hl <= n_hl[31:0];
            o_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end
endmodule
`default_nettype wire

// ===== design/fvn_coord.sv =====
// ----------------------------------------------------------------------------
// fvn_coord: index to Q1.F coordinate
// Clamps the index and computes (c*2^F + d/2) / d with a pipelined restoring
// divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_coord #(
    parameter int unsigned MAX_RESOLUTION = fvn_pkg::MAX_RES_DEF,
    parameter int unsigned FRACTION_BITS  = fvn_pkg::FRAC_DEF,
    localparam int unsigned DW = $clog2(MAX_RESOLUTION),
    localparam int unsigned QW = FRACTION_BITS + 1,
    localparam int unsigned NW = DW + FRACTION_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_idx,
    input  wire logic [DW-1:0] i_d,
    output logic      [QW-1:0] o_u
);
    import fvn_pkg::*;

    logic [DW-1:0] cl;
    logic [NW-1:0] num;
    logic [NW-1:0] r_num [QW+1];
    logic [DW:0]   r_rem [QW+1];
    logic [DW-1:0] r_div [QW+1];
    logic          r_z   [QW+1];

    assign cl  = (i_idx > i_d) ? i_d : i_idx;
    assign num = NW'({cl, {FRACTION_BITS{1'b0}}}) + NW'(i_d >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= num;
            r_rem[0] <= '0;
            r_div[0] <= i_d;
            r_z[0]   <= (i_d == '0);
        end
    end

    // Quotient fits in QW bits; the top NW-QW dividend bits are below d.
    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [DW+1:0] tr;
        logic [DW+1:0] df;
        logic [NW-1:0] nn;
        always_comb begin
            if (s == 0) begin
                tr = {2'b0, r_num[s][NW-1 -: DW]};
                tr = {tr[DW:0], r_num[s][NW-1-DW]};
                nn = {r_num[s][NW-2-DW:0], {(DW+1){1'b0}}};
            end else begin
                tr = {r_rem[s], r_num[s][NW-1]};
                nn = {r_num[s][NW-2:0], 1'b0};
            end
            df = tr - {2'b0, r_div[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= df[DW+1] ? tr[DW:0] : df[DW:0];
                r_num[s+1] <= {nn[NW-1:1], ~df[DW+1]};
                r_div[s+1] <= r_div[s];
                r_z[s+1]   <= r_z[s];
            end
        end
    end

    assign o_u = r_z[QW] ? '0 : r_num[QW][QW-1:0];
endmodule
`default_nettype wire

// ===== design/fvn_octave.sv =====
// ----------------------------------------------------------------------------
// fvn_octave: one noise octave
// Lattice cell, four corner hashes, smoothstep weights and the bilinear blend,
// spread over registered stages that advance under i_en.
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_octave #(
    parameter int unsigned FRACTION_BITS = fvn_pkg::FRAC_DEF,
    parameter int unsigned OCT = 0,
    localparam int unsigned F = FRACTION_BITS,
    localparam int unsigned SH = OCT + 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [F:0]   i_u,
    input  wire logic [F:0]   i_v,
    input  wire logic [63:0]  i_seed,
    input  wire logic [31:0]  i_tile_x,
    input  wire logic [31:0]  i_tile_y,
    output logic      [F-1:0] o_val
);
    import fvn_pkg::*;

    // Stage 1: cell index and fraction.
    logic [63:0] r_xi, r_yi, r_key;
    logic [F-1:0] r_tx, r_ty;
    logic [F+SH:0] pu, pv;
    assign pu = {{SH{1'b0}}, i_u} << SH;
    assign pv = {{SH{1'b0}}, i_v} << SH;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xi  <= ({{32{i_tile_x[31]}}, i_tile_x} << SH) + 64'(pu[F+SH:F]);
            r_yi  <= ({{32{i_tile_y[31]}}, i_tile_y} << SH) + 64'(pv[F+SH:F]);
            r_key <= i_seed + 64'(OCT);
            r_tx  <= pu[F-1:0];
            r_ty  <= pv[F-1:0];
        end
    end

    // Stage 2: corner coordinates.
    logic [63:0] r_x0, r_x1, r_y0, r_y1, r_k2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= r_xi;
            r_x1 <= r_xi + 64'd1;
            r_y0 <= r_yi;
            r_y1 <= r_yi + 64'd1;
            r_k2 <= r_key;
        end
    end

    // Products by the constants (registered in fvn_mul64): x*KX, y*KY, key*KK.
    logic [63:0] px0, px1, py0, py1, pk;
    fvn_mul64 u_mx0 (.i_clk, .i_en, .i_a(r_x0), .i_b(HASH_KX), .o_p(px0));
    fvn_mul64 u_mx1 (.i_clk, .i_en, .i_a(r_x1), .i_b(HASH_KX), .o_p(px1));
    fvn_mul64 u_my0 (.i_clk, .i_en, .i_a(r_y0), .i_b(HASH_KY), .o_p(py0));
    fvn_mul64 u_my1 (.i_clk, .i_en, .i_a(r_y1), .i_b(HASH_KY), .o_p(py1));
    fvn_mul64 u_mk  (.i_clk, .i_en, .i_a(r_k2), .i_b(HASH_KK), .o_p(pk));

    // Stage: xor and first shift-xor for four corners (00,10,01,11).
    logic [63:0] r_h [4];
    logic [63:0] hx [4];
    assign hx[0] = px0 ^ py0 ^ pk;
    assign hx[1] = px1 ^ py0 ^ pk;
    assign hx[2] = px0 ^ py1 ^ pk;
    assign hx[3] = px1 ^ py1 ^ pk;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) r_h[c] <= hx[c] ^ (hx[c] >> 29);
        end
    end

    logic [63:0] hm [4];
    logic [F-1:0] r_n [4];
    for (genvar c = 0; c < 4; c++) begin : g_mix
        fvn_mul64 u_mm (.i_clk, .i_en, .i_a(r_h[c]), .i_b(HASH_KM), .o_p(hm[c]));
        logic [63:0] hf;
        assign hf = hm[c] ^ (hm[c] >> 32);
        always_ff @(posedge i_clk) begin
            if (i_en) r_n[c] <= hf[23 -: F];
        end
    end
    // Corner values are registered in r_n.

    // Weight path: smoothstep, delayed to match.
    logic [2*F-1:0] r_t2x, r_t2y;
    logic [F+1:0]   r_kx, r_ky;
    logic [F-1:0]   r_t2xs, r_t2ys;
    logic [F+1:0]   r_kx2, r_ky2;
    logic [2*F+1:0] r_wpx, r_wpy;
    logic [F:0]     r_tx_d, r_ty_d;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2x  <= (2*F)'(r_tx) * (2*F)'(r_tx);
            r_t2y  <= (2*F)'(r_ty) * (2*F)'(r_ty);
            r_kx   <= (F+2)'(3) << F;
            r_ky   <= (F+2)'(3) << F;
            r_kx2  <= r_kx - {r_tx_d, 1'b0};
            r_ky2  <= r_ky - {r_ty_d, 1'b0};
            r_t2xs <= r_t2x[2*F-1:F];
            r_t2ys <= r_t2y[2*F-1:F];
            r_wpx  <= (2*F+2)'(r_t2xs) * (2*F+2)'(r_kx2);
            r_wpy  <= (2*F+2)'(r_t2ys) * (2*F+2)'(r_ky2);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx_d <= (F+1)'(r_tx);
            r_ty_d <= (F+1)'(r_ty);
        end
    end
    // r_wp is delayed through the g_wd registers to line up with r_n.
    logic [F:0] wxd [5];
    logic [F:0] wyd [5];
    assign wxd[0] = r_wpx[2*F:F];
    assign wyd[0] = r_wpy[2*F:F];
    for (genvar s = 0; s < 4; s++) begin : g_wd
        logic [F:0] r_a, r_b;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a <= wxd[s];
                r_b <= wyd[s];
            end
        end
        assign wxd[s+1] = r_a;
        assign wyd[s+1] = r_b;
    end

    // Blend along x, then along y.
    logic [2*F+1:0] r_a0, r_a1, r_b0, r_b1;
    logic [F:0] r_wy1, r_wy2;
    logic [F-1:0] r_nx0, r_nx1;
    logic [F:0] one;
    logic [2*F+1:0] r_c0, r_c1;
    assign one = (F+1)'(1) << F;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0  <= (2*F+2)'(r_n[0]) * (2*F+2)'(one - wxd[4]);
            r_a1  <= (2*F+2)'(r_n[1]) * (2*F+2)'(wxd[4]);
            r_b0  <= (2*F+2)'(r_n[2]) * (2*F+2)'(one - wxd[4]);
            r_b1  <= (2*F+2)'(r_n[3]) * (2*F+2)'(wxd[4]);
            r_wy1 <= wyd[4];
            r_nx0 <= F'((r_a0 + r_a1) >> F);
            r_nx1 <= F'((r_b0 + r_b1) >> F);
            r_wy2 <= r_wy1;
            r_c0  <= (2*F+2)'(r_nx0) * (2*F+2)'(one - r_wy2);
            r_c1  <= (2*F+2)'(r_nx1) * (2*F+2)'(r_wy2);
            o_val <= F'((r_c0 + r_c1) >> F);
        end
    end
endmodule
`default_nettype wire

// ===== design/fractal_value_noise_height.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_height: fractal 2D value noise heightfield sampler
// Index scaling, parallel octave pipelines and the output register.
// ----------------------------------------------------------------------------
// One beat in (column, row) gives one beat out (height), in order. The block
// takes a beat every cycle while the output is not stalled; each beat passes
// through the coordinate divider (F+2 stages), the octave pipeline (12 stages)
// and the output register. The whole pipeline advances whenever the output
// register is empty or is being drained, so a stall holds every stage and
// loses nothing. The octave datapath is a set of 64-bit multiply-xor hashes
// built from registered 32x32 partial products. The user must write
// configuration only while idle; the block itself does not enforce this.
`default_nettype none
module fractal_value_noise_height #(
    parameter int unsigned MAX_RESOLUTION = fvn_pkg::MAX_RES_DEF,
    parameter int unsigned OCTAVES        = fvn_pkg::OCTAVES_DEF,
    parameter int unsigned FRACTION_BITS  = fvn_pkg::FRAC_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [fvn_pkg::IDX_W-1:0]      i_column,
    input  wire logic [fvn_pkg::IDX_W-1:0]      i_row,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [fvn_pkg::HEIGHT_W-1:0]   o_height,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fvn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [63:0]                    i_cfg_data
);
    import fvn_pkg::*;
    localparam int unsigned F   = FRACTION_BITS;
    localparam int unsigned DW  = $clog2(MAX_RESOLUTION);
    localparam int unsigned LAT = (F + 2) + 12;

    logic [63:0]    r_seed;
    logic [31:0]    r_tile_x, r_tile_y;
    logic [RES_W-1:0] r_res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_tile_x <= '0;
            r_tile_y <= '0;
            r_res <= RES_W'(256);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SEED:       r_seed   <= i_cfg_data;
                REG_TILE_X:     r_tile_x <= i_cfg_data[31:0];
                REG_TILE_Y:     r_tile_y <= i_cfg_data[31:0];
                REG_RESOLUTION: r_res    <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective resolution minus one, as a DW-bit divisor.
    logic [DW:0] res_c;
    logic [DW-1:0] dd;
    logic [DW-1:0] col_w, row_w;
    always_comb begin
        if (r_res == '0) res_c = (DW+1)'(1);
        else if (32'(r_res) > MAX_RESOLUTION) res_c = (DW+1)'(MAX_RESOLUTION);
        else res_c = (DW+1)'(r_res);
    end
    assign dd = DW'(res_c - 1'b1);
    // Clamp on the full index before it is narrowed to the divisor width.
    assign col_w = (32'(i_column) > 32'(dd)) ? dd : DW'(i_column);
    assign row_w = (32'(i_row) > 32'(dd)) ? dd : DW'(i_row);

    // Pipeline advance and valid chain.
    logic en;
    logic [LAT-1:0] r_vld;
    t_beat_ctl tail;
    assign tail.valid = r_vld[LAT-1];
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    logic [F:0] u, v;
    fvn_coord #(.MAX_RESOLUTION(MAX_RESOLUTION), .FRACTION_BITS(F)) u_cu (
        .i_clk, .i_en(en), .i_idx(col_w), .i_d(dd), .o_u(u));
    fvn_coord #(.MAX_RESOLUTION(MAX_RESOLUTION), .FRACTION_BITS(F)) u_cv (
        .i_clk, .i_en(en), .i_idx(row_w), .i_d(dd), .o_u(v));

    logic [F-1:0] oval [OCTAVES];
    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        fvn_octave #(.FRACTION_BITS(F), .OCT(k)) u_oct (
            .i_clk, .i_en(en), .i_u(u), .i_v(v), .i_seed(r_seed),
            .i_tile_x(r_tile_x), .i_tile_y(r_tile_y), .o_val(oval[k]));
    end

    // Octave k scaled by 2^-(k+1); the sum stays below one.
    logic [F-1:0] sum;
    always_comb begin
        sum = '0;
        for (int k = 0; k < OCTAVES; k++) sum = sum + (oval[k] >> (k + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= tail.valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) o_height <= HEIGHT_W'({sum, {(HEIGHT_W-F){1'b0}}});
    end

    // A held result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_height)) else $error("hold");
    // The output valid takes the tail of the valid chain whenever the pipeline advances.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (o_valid == $past(tail.valid))) else $error("latency");
    // Ready follows the output register.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready");
endmodule
`default_nettype wire
